// ===== sv/rfrh_pkg.sv =====
// Shared types and constants for the record file request handler.
// Stream payload layouts, register indexes, opcodes and error codes.
// No dependencies.
package rfrh_pkg;

	localparam int REC_PER_PAGE = 126;
	localparam logic [7:0] REC_SIZE = 8'd128;
	localparam logic [1:0] WINDOW_TOP = 2'b11;     // 0xC000 base, top two bits
	localparam logic [7:0] OPEN_FLAGS = 8'h0C;
	localparam logic [7:0] ERR_ATTR = 8'h40;
	localparam logic [7:0] ERR_EOF = 8'hA0;
	localparam logic [7:0] ERR_NAME = 8'hE0;

	localparam logic [7:0] OP_OPEN = 8'd0;
	localparam logic [7:0] OP_CLOSE = 8'd1;
	localparam logic [7:0] OP_READ = 8'd2;

	localparam logic [7:0] NAME_ONE_A = 8'h42;     // 'B'
	localparam logic [7:0] NAME_ONE_B = 8'h49;     // 'I'
	localparam logic [7:0] NAME_TWO_A = 8'h52;     // 'R'
	localparam logic [7:0] NAME_TWO_B = 8'h4F;     // 'O'

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FILE_ONE_FIRST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FILE_TWO_FIRST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILE_TWO_END = 2'd2;

	localparam logic [15:0] RST_FILE_ONE_FIRST = 16'hFFF1;
	localparam logic [15:0] RST_FILE_TWO_FIRST = 16'hFFFC;
	localparam logic [15:0] RST_FILE_TWO_END = 16'hFFFF;

	// floor(x/126) == (x*DIV_MUL) >> DIV_SHIFT for any 16-bit x
	localparam int DIV_SHIFT = 23;
	localparam logic [16:0] DIV_MUL = 17'd66577;

	localparam int IN_W = 88;
	localparam int IN_BYTES_W = 88;
	localparam int OUT_W = 98;
	localparam int OUT_BYTES_W = 104;

	// packed structs: last member sits in the lowest bits
	typedef struct packed {
		logic [7:0]  name_second;
		logic [7:0]  name_first;
		logic [15:0] record_number;
		logic [7:0]  got_length_in;
		logic [7:0]  request_length;
		logic [15:0] buffer_address;
		logic [7:0]  flag_byte;
		logic [15:0] request_address;
	} req_t;

	typedef struct packed {
		logic [OUT_BYTES_W-OUT_W-1:0] pad;
		logic [7:0]  got_length_out;
		logic [15:0] record_out;
		logic [15:0] copy_destination;
		logic [15:0] source_offset;
		logic [15:0] bank_page;
		logic        copy_record;
		logic [7:0]  flag_out;
		logic [15:0] write_back_address;
		logic        write_back;
	} rsp_t;

endpackage

// ===== sv/record_file_request_handler.sv =====
// Record file request handler: decodes one request block per transaction.
// Pipeline: input register, one pass of decode logic, result register; throughput one
//   request per cycle unless a stalled result (m_tready low) holds the pipeline.
// Reset (arst_n low, asynchronous): both stages empty, page registers take
//   their power-on values. Config writes are always ready.
// Depends on rfrh_pkg.
module record_file_request_handler (
	input  logic                              clk,
	input  logic                              arst_n,
	// request_address, flag_byte, buffer_address, request_length,
	// got_length_in, record_number, name_first, name_second
	input  logic [rfrh_pkg::IN_BYTES_W-1:0]   s_tdata,
	input  logic [7:0]                        s_tuser,   // opcode
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// write_back, write_back_address, flag_out, copy_record, bank_page,
	// source_offset, copy_destination, record_out, got_length_out, zero pad
	output logic [rfrh_pkg::OUT_BYTES_W-1:0]  m_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rfrh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [15:0]                       cfg_data
);
	import rfrh_pkg::*;

	logic [15:0] file_one_first_q, file_two_first_q, file_two_end_q;

	req_t        req_s1;
	logic [7:0]  op_s1;
	logic        valid_s1;
	rsp_t        rsp_q;
	logic        valid_q;

	logic        adv_s1;
	rsp_t        rsp_d;

	logic [32:0] prod;
	logic [9:0]  quot;
	logic [15:0] quot_x126;
	logic [6:0]  rem;
	logic [15:0] first, next, blk;
	logic        is_one, is_two;

	assign cfg_ready = 1'b1;
	assign adv_s1 = valid_s1 && (!valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign m_tvalid = valid_q;
	assign m_tdata = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_one_first_q <= RST_FILE_ONE_FIRST;
			file_two_first_q <= RST_FILE_TWO_FIRST;
			file_two_end_q <= RST_FILE_TWO_END;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FILE_ONE_FIRST: file_one_first_q <= cfg_data;
				CFG_FILE_TWO_FIRST: file_two_first_q <= cfg_data;
				CFG_FILE_TWO_END:   file_two_end_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (!valid_q || m_tready) valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1 <= req_t'(s_tdata[IN_W-1:0]);
			op_s1 <= s_tuser;
		end
		if (adv_s1) rsp_q <= rsp_d;
	end

	// record / 126 by reciprocal multiply, remainder by shift-and-subtract
	always_comb begin
		prod = {17'd0, req_s1.record_number} * {16'd0, DIV_MUL};
		quot = prod[DIV_SHIFT+9:DIV_SHIFT];
		quot_x126 = {quot[8:0], 7'd0} - {5'd0, quot, 1'b0};
		rem = 7'(req_s1.record_number - quot_x126);
	end

	always_comb begin
		is_one = (req_s1.name_first == NAME_ONE_A) && (req_s1.name_second == NAME_ONE_B);
		is_two = (req_s1.name_first == NAME_TWO_A) && (req_s1.name_second == NAME_TWO_B);
		first = is_one ? file_one_first_q : file_two_first_q;
		next = is_one ? file_two_first_q : file_two_end_q;
		blk = {6'd0, quot} + first;

		rsp_d = '0;
		rsp_d.write_back_address = req_s1.request_address;
		rsp_d.flag_out = req_s1.flag_byte;
		rsp_d.source_offset = {WINDOW_TOP, 14'd0};
		rsp_d.record_out = req_s1.record_number;
		rsp_d.got_length_out = req_s1.got_length_in;

		if (op_s1 == OP_CLOSE) begin
			// ignored
		end else if (req_s1.request_length != REC_SIZE) begin
			rsp_d.flag_out = req_s1.flag_byte | ERR_ATTR;
			rsp_d.write_back = 1'b1;
		end else if (op_s1 == OP_READ) begin
			rsp_d.write_back = 1'b1;
			if (!is_one && !is_two) begin
				rsp_d.flag_out = req_s1.flag_byte | ERR_NAME;
			end else if (blk >= next || blk < file_one_first_q) begin
				rsp_d.flag_out = req_s1.flag_byte | ERR_EOF;
			end else begin
				rsp_d.copy_record = 1'b1;
				rsp_d.bank_page = blk;
				rsp_d.source_offset = {WINDOW_TOP, rem, 7'd0};
				rsp_d.copy_destination = req_s1.buffer_address;
				rsp_d.record_out = req_s1.record_number + 16'd1;
				rsp_d.got_length_out = REC_SIZE;
			end
		end else if (op_s1 != OP_OPEN || req_s1.flag_byte != OPEN_FLAGS) begin
			rsp_d.flag_out = req_s1.flag_byte | ERR_ATTR;
			rsp_d.write_back = 1'b1;
		end
	end

endmodule

// ===== sv/rfrh_checker.sv =====
// Port-level checks for record_file_request_handler, bound into that module.
// Depends on rfrh_pkg.
module rfrh_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [rfrh_pkg::OUT_BYTES_W-1:0]  m_tdata,
	input logic                              m_tvalid,
	input logic                              m_tready
);
	import rfrh_pkg::*;

	rsp_t rsp;
	assign rsp = rsp_t'(m_tdata);

	// a copy always implies a write-back and an offset inside the window
	a_copy_wb: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && rsp.copy_record |-> rsp.write_back && rsp.source_offset[15:14] == WINDOW_TOP)
		else $error("copy without write-back or offset outside window");

	a_nocopy_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !rsp.copy_record |-> rsp.bank_page == 16'd0
			&& rsp.copy_destination == 16'd0 && rsp.source_offset == {WINDOW_TOP, 14'd0})
		else $error("copy fields not cleared on a result without copy");

	// a new result needs an input transaction that went through the input and result registers
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result appeared without an input transaction");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind record_file_request_handler rfrh_checker u_rfrh_checker (.*);
